### sv/tte_pkg.sv
// tte_pkg: shared constants, opcodes and controller/datapath command types
// for the timer table engine; no dependencies
package tte_pkg;

  localparam int NUM_SLOTS_DEF   = 16;
  localparam int MS_PER_TICK_DEF = 200;
  localparam int OWNER_LIMIT     = 100;
  localparam int MAX_RESULTS     = 16;
  localparam int TICK_W          = 16;
  localparam int DELAY_W         = 24;
  localparam int SLOT_OUT_W      = 6;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam logic [1:0] MODE_FREE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_EXEC,
    CMD_DIV,
    CMD_WALK_INIT,
    CMD_WALK
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } tte_ctl_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
  } tte_sts_t;

endpackage

### sv/tte_datapath.sv
// tte_datapath: slot table, live list, free stack, tick counter, reciprocal
// divider and list walker; uses tte_pkg
module tte_datapath import tte_pkg::*; #(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int MS_PER_TICK = MS_PER_TICK_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tte_ctl_t              ctl,
  output tte_sts_t              sts,
  input  logic [2:0]            in_opcode,
  input  logic [5:0]            in_slot_id,
  input  logic                  in_one_shot,
  input  logic [7:0]            in_owner_module,
  input  logic [DELAY_W-1:0]    in_delay_ms,
  output logic                  out_strobe,
  output logic                  out_kind,
  output logic                  out_status,
  output logic [SLOT_OUT_W-1:0] out_slot_out,
  output logic                  out_last
);

  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LW  = $clog2(NUM_SLOTS + 1);
  localparam int RW  = $clog2(MAX_RESULTS + 1);
  localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);
  // floor(x / d) = (x * ceil(2^sh / d)) >> sh, sh = width + ceil(log2 d)
  localparam int DIV_SH = DELAY_W + $clog2(MS_PER_TICK);
  localparam int MW     = DELAY_W + 1;
  localparam int PW     = DIV_SH + DELAY_W;
  localparam logic [63:0] DIV_M64 =
    ((64'd1 << DIV_SH) + 64'(MS_PER_TICK) - 64'd1) / 64'(MS_PER_TICK);
  localparam logic [MW-1:0] DIV_M = DIV_M64[MW-1:0];

  logic [1:0]        mode_r     [NUM_SLOTS];
  logic              oneshot_r  [NUM_SLOTS];
  logic [6:0]        owner_r    [NUM_SLOTS];
  logic [TICK_W-1:0] period_r   [NUM_SLOTS];
  logic [TICK_W-1:0] deadline_r [NUM_SLOTS];
  logic [LW-1:0]     next_r     [NUM_SLOTS];
  logic [LW-1:0]     prev_r     [NUM_SLOTS];
  logic [SW-1:0]     stack_r    [NUM_SLOTS];
  logic [LW-1:0]     head_r, free_cnt_r, live_cnt_r;
  logic [TICK_W-1:0] now_r;

  logic [2:0]         op_r;
  logic [5:0]         sid_r;
  logic               os_r;
  logic [7:0]         own_r;
  logic [DELAY_W-1:0] quo_r;
  logic               dcnt_r;

  logic [LW-1:0]     cur_r;
  logic [LW-1:0]     steps_r;
  logic [RW-1:0]     k_r;
  logic              pend_r;
  logic [SW-1:0]     pend_id_r;

  logic [SW-1:0]     s_idx, cur_idx, pop_id;
  logic              s_ok, exp_hit, walk_end;
  logic [PW-1:0]     div_prod;

  assign s_idx   = sid_r[SW-1:0];
  assign s_ok    = ({1'b0, sid_r} < 7'(NUM_SLOTS)) && (mode_r[s_idx] != MODE_FREE);
  assign cur_idx = cur_r[SW-1:0];
  assign pop_id  = stack_r[SW'(free_cnt_r - LW'(1))];
  assign div_prod = PW'(quo_r) * PW'(DIV_M);
  assign exp_hit = (mode_r[cur_idx] == MODE_RUN) && (deadline_r[cur_idx] <= now_r);
  assign walk_end = (cur_r >= NIL) || (steps_r >= NIL);

  assign sts.div_done  = !dcnt_r;
  assign sts.walk_done = walk_end;

  always_ff @(posedge clk) begin
    out_strobe <= 1'b0;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        mode_r[i]     <= MODE_FREE;
        oneshot_r[i]  <= 1'b0;
        owner_r[i]    <= '0;
        period_r[i]   <= '0;
        deadline_r[i] <= '0;
        next_r[i]     <= NIL;
        prev_r[i]     <= NIL;
        stack_r[i]    <= SW'(NUM_SLOTS - 1 - i);
      end
      head_r     <= NIL;
      free_cnt_r <= LW'(NUM_SLOTS);
      live_cnt_r <= '0;
      now_r      <= '0;
      dcnt_r     <= 1'b0;
      pend_r     <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      unique case (ctl.cmd)
        CMD_NONE: ;
        CMD_LATCH: begin
          op_r   <= in_opcode;
          sid_r  <= in_slot_id;
          os_r   <= in_one_shot;
          own_r  <= in_owner_module;
          quo_r  <= in_delay_ms;
          dcnt_r <= 1'b1;
        end
        CMD_DIV: begin
          // delay over ticks by reciprocal multiply
          quo_r  <= div_prod[DIV_SH +: DELAY_W];
          dcnt_r <= 1'b0;
        end
        CMD_EXEC: begin
          out_strobe   <= 1'b1;
          out_kind     <= 1'b0;
          out_status   <= 1'b1;
          out_slot_out <= '0;
          out_last     <= 1'b1;
          if (op_r == OP_CREATE) begin
            if (own_r < 8'(OWNER_LIMIT) && free_cnt_r != '0) begin
              free_cnt_r <= free_cnt_r - LW'(1);
              prev_r[pop_id]     <= NIL;
              next_r[pop_id]     <= head_r;
              if (head_r < NIL) prev_r[head_r[SW-1:0]] <= LW'(pop_id);
              head_r             <= LW'(pop_id);
              live_cnt_r         <= live_cnt_r + LW'(1);
              mode_r[pop_id]     <= MODE_STOP;
              oneshot_r[pop_id]  <= os_r;
              owner_r[pop_id]    <= own_r[6:0];
              period_r[pop_id]   <= '0;
              deadline_r[pop_id] <= '0;
              out_status   <= 1'b0;
              out_slot_out <= SLOT_OUT_W'(pop_id);
            end
          end else if (op_r <= OP_STOP && s_ok) begin
            if (op_r == OP_DELETE) begin
              if (live_cnt_r != '0) begin
                out_status <= 1'b0;
                live_cnt_r <= live_cnt_r - LW'(1);
                if (live_cnt_r == LW'(1)) begin
                  head_r <= NIL;
                end else begin
                  if (prev_r[s_idx] < NIL) next_r[prev_r[s_idx][SW-1:0]] <= next_r[s_idx];
                  else head_r <= next_r[s_idx];
                  if (next_r[s_idx] < NIL) prev_r[next_r[s_idx][SW-1:0]] <= prev_r[s_idx];
                end
                mode_r[s_idx]     <= MODE_FREE;
                oneshot_r[s_idx]  <= 1'b0;
                owner_r[s_idx]    <= '0;
                period_r[s_idx]   <= '0;
                deadline_r[s_idx] <= '0;
                next_r[s_idx]     <= NIL;
                prev_r[s_idx]     <= NIL;
                if (free_cnt_r < NIL) begin
                  stack_r[free_cnt_r[SW-1:0]] <= s_idx;
                  free_cnt_r <= free_cnt_r + LW'(1);
                end
              end
            end else if (op_r == OP_START) begin
              out_status        <= 1'b0;
              mode_r[s_idx]     <= MODE_RUN;
              period_r[s_idx]   <= quo_r[TICK_W-1:0];
              deadline_r[s_idx] <= now_r + quo_r[TICK_W-1:0];
            end else begin
              out_status    <= 1'b0;
              mode_r[s_idx] <= MODE_STOP;
            end
          end
        end
        CMD_WALK_INIT: begin
          now_r   <= now_r + TICK_W'(1);
          cur_r   <= head_r;
          steps_r <= '0;
          k_r     <= '0;
          pend_r  <= 1'b0;
        end
        CMD_WALK: begin
          // one result is held back so that last can be set on it
          if (!walk_end) begin
            if (exp_hit) begin
              if (k_r < RW'(MAX_RESULTS)) begin
                if (pend_r) begin
                  out_strobe   <= 1'b1;
                  out_kind     <= 1'b1;
                  out_status   <= 1'b0;
                  out_slot_out <= SLOT_OUT_W'(pend_id_r);
                  out_last     <= 1'b0;
                end
                pend_r    <= 1'b1;
                pend_id_r <= cur_idx;
                k_r       <= k_r + RW'(1);
              end
              if (oneshot_r[cur_idx]) mode_r[cur_idx] <= MODE_STOP;
              else deadline_r[cur_idx] <= now_r + period_r[cur_idx];
            end
            cur_r   <= next_r[cur_idx];
            steps_r <= steps_r + LW'(1);
          end else begin
            out_strobe   <= 1'b1;
            out_kind     <= pend_r;
            out_status   <= 1'b0;
            out_slot_out <= pend_r ? SLOT_OUT_W'(pend_id_r) : '0;
            out_last     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### sv/tte_ctrl.sv
// tte_ctrl: command sequencer for the timer table engine; uses tte_pkg
module tte_ctrl import tte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_opcode,
  input  tte_sts_t   sts,
  output tte_ctl_t   ctl,
  output logic       busy
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_EXEC, S_TINIT, S_WALK, S_DONE} state_t;
  state_t state_r;

  always_comb begin
    unique case (state_r)
      S_IDLE:  ctl.cmd = start ? CMD_LATCH : CMD_NONE;
      S_DIV:   ctl.cmd = sts.div_done ? CMD_EXEC : CMD_DIV;
      S_EXEC:  ctl.cmd = CMD_EXEC;
      S_TINIT: ctl.cmd = CMD_WALK_INIT;
      S_WALK:  ctl.cmd = CMD_WALK;
      S_DONE:  ctl.cmd = CMD_NONE;
      default: ctl.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) begin
          busy <= 1'b1;
          if (in_opcode == OP_TICK) state_r <= S_TINIT;
          else if (in_opcode == OP_START) state_r <= S_DIV;
          else state_r <= S_EXEC;
        end
        S_DIV:   if (sts.div_done) state_r <= S_DONE;
        S_EXEC:  state_r <= S_DONE;
        S_TINIT: state_r <= S_WALK;
        S_WALK:  if (sts.walk_done) state_r <= S_DONE;
        S_DONE: begin
          state_r <= S_IDLE;
          busy    <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/timer_table_engine_top.sv
// timer_table_engine_top: top level of the timer table engine
// instantiates tte_ctrl and tte_datapath; uses tte_pkg
//
// usage
//  - a request is taken at a rising edge with start high and busy low;
//    its fields sit on in_opcode, in_slot_id, in_one_shot, in_owner_module
//    and in_delay_ms
//  - each result is on out_kind, out_status, out_slot_out and out_last for
//    exactly one cycle, marked by out_strobe; the receiver cannot stall
//  - create, delete, stop and bad opcodes: one reply per request
//  - start: the period comes from a reciprocal multiply by the constant
//    tick length
//  - tick: the walker visits one live slot per cycle in list order;
//    expiries stream out, the last flagged by out_last, and a tick with no
//    expiry gives one reply
//  - synchronous active-low reset empties the table, stacks ids ascending
//    with 0 on top and zeroes the tick counter
module timer_table_engine_top import tte_pkg::*; #(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int MS_PER_TICK = MS_PER_TICK_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_opcode,
  input  logic [5:0]            in_slot_id,
  input  logic                  in_one_shot,
  input  logic [7:0]            in_owner_module,
  input  logic [DELAY_W-1:0]    in_delay_ms,
  output logic                  out_strobe,
  output logic                  out_kind,
  output logic                  out_status,
  output logic [SLOT_OUT_W-1:0] out_slot_out,
  output logic                  out_last
);

  tte_ctl_t ctl;
  tte_sts_t sts;

  // sequencer
  tte_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_opcode, .sts, .ctl, .busy
  );

  // table storage and walker
  tte_datapath #(.NUM_SLOTS(NUM_SLOTS), .MS_PER_TICK(MS_PER_TICK)) u_dp (
    .clk, .rst_n, .ctl, .sts,
    .in_opcode, .in_slot_id, .in_one_shot, .in_owner_module, .in_delay_ms,
    .out_strobe, .out_kind, .out_status, .out_slot_out, .out_last
  );

  // a result is only produced while a request is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result outside a request");

  // a final result ends the request next cycle
  a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> !busy) else $error("busy after last result");

  // a replied command never reports an expired slot kind with a reject
  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind) |-> !out_status) else $error("rejected expiry");

endmodule

### dv/tte_checker.sv
// tte_checker: watches the request and result ports of the timer table
// engine, predicts each request's results and compares them; uses tte_pkg
module tte_checker import tte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [2:0]            in_opcode,
  input  logic [5:0]            in_slot_id,
  input  logic                  in_one_shot,
  input  logic [7:0]            in_owner_module,
  input  logic [DELAY_W-1:0]    in_delay_ms,
  input  logic                  out_strobe,
  input  logic                  out_kind,
  input  logic                  out_status,
  input  logic [SLOT_OUT_W-1:0] out_slot_out,
  input  logic                  out_last,
  output int                    fail_count,
  output int                    pending
);

  localparam int NS  = NUM_SLOTS_DEF;
  localparam int NIL = NS;

  typedef struct packed {
    logic                  kind;
    logic                  status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  last;
  } reply_t;

  reply_t replies_due[$];

  logic [1:0]  mode_q [NS];
  logic        oneshot_q [NS];
  logic [15:0] period_q [NS];
  logic [15:0] deadline_q [NS];
  int          next_q [NS];
  int          prev_q [NS];
  int          head_q;
  int          free_ids [NS];
  int          free_n;
  int          live_n;
  logic [15:0] now_q;

  function automatic reply_t mk(logic k, logic st, int s, logic l);
    reply_t r;
    r.kind = k; r.status = st; r.slot = s[SLOT_OUT_W-1:0]; r.last = l;
    return r;
  endfunction

  task automatic table_reset();
    for (int i = 0; i < NS; i++) begin
      mode_q[i] = MODE_FREE; oneshot_q[i] = 0; period_q[i] = 0;
      deadline_q[i] = 0; next_q[i] = NIL; prev_q[i] = NIL;
      free_ids[i] = NS - 1 - i;
    end
    head_q = NIL; free_n = NS; live_n = 0; now_q = 0;
  endtask

  task automatic predict_request(logic [2:0] op, logic [5:0] sid, logic osh,
                                 logic [7:0] own, logic [DELAY_W-1:0] dly);
    int s, cur, k, steps;
    logic [15:0] per;
    reply_t fired [$];
    if (op == OP_CREATE) begin
      if (own >= OWNER_LIMIT || free_n == 0) begin
        replies_due.push_back(mk(0, 1, 0, 1));
      end else begin
        free_n--;
        s = free_ids[free_n];
        prev_q[s] = NIL; next_q[s] = head_q;
        if (head_q < NS) prev_q[head_q] = s;
        head_q = s; live_n++;
        mode_q[s] = MODE_STOP; oneshot_q[s] = osh;
        period_q[s] = 0; deadline_q[s] = 0;
        replies_due.push_back(mk(0, 0, s, 1));
      end
    end else if (op == OP_TICK) begin
      now_q = now_q + 16'd1;
      cur = head_q; steps = 0; k = 0;
      while (cur < NS && steps < NS) begin
        if (mode_q[cur] == MODE_RUN && deadline_q[cur] <= now_q) begin
          if (k < MAX_RESULTS) begin
            fired.push_back(mk(1, 0, cur, 0));
            k++;
          end
          if (oneshot_q[cur]) mode_q[cur] = MODE_STOP;
          else deadline_q[cur] = now_q + period_q[cur];
        end
        cur = next_q[cur]; steps++;
      end
      if (k == 0) begin
        replies_due.push_back(mk(0, 0, 0, 1));
      end else begin
        fired[k-1].last = 1;
        foreach (fired[i]) replies_due.push_back(fired[i]);
      end
    end else if (op > OP_TICK || sid >= NS || mode_q[sid] == MODE_FREE) begin
      replies_due.push_back(mk(0, 1, 0, 1));
    end else begin
      s = sid;
      if (op == OP_DELETE) begin
        live_n--;
        if (live_n == 0) head_q = NIL;
        else begin
          if (prev_q[s] < NS) next_q[prev_q[s]] = next_q[s];
          else head_q = next_q[s];
          if (next_q[s] < NS) prev_q[next_q[s]] = prev_q[s];
        end
        mode_q[s] = MODE_FREE; oneshot_q[s] = 0; period_q[s] = 0;
        deadline_q[s] = 0; next_q[s] = NIL; prev_q[s] = NIL;
        if (free_n < NS) begin
          free_ids[free_n] = s; free_n++;
        end
      end else if (op == OP_START) begin
        per = 16'(dly / MS_PER_TICK_DEF);
        mode_q[s] = MODE_RUN; period_q[s] = per; deadline_q[s] = now_q + per;
      end else begin
        mode_q[s] = MODE_STOP;
      end
      replies_due.push_back(mk(0, 0, 0, 1));
    end
  endtask

  assign pending = replies_due.size();

  always @(posedge clk) begin
    reply_t e;
    if (!rst_n) begin
      table_reset();
      replies_due.delete();
    end else begin
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          $error("result with nothing expected: slot_out %0d", out_slot_out);
          fail_count++;
        end else begin
          e = replies_due.pop_front();
          if (out_kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, out_kind); fail_count++;
          end
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); fail_count++;
          end
          if (out_slot_out !== e.slot) begin
            $error("slot_out exp %0d got %0d", e.slot, out_slot_out); fail_count++;
          end
          if (out_last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_last); fail_count++;
          end
        end
      end
      if (start && !busy)
        predict_request(in_opcode, in_slot_id, in_one_shot, in_owner_module,
                        in_delay_ms);
    end
  end

  initial fail_count = 0;

endmodule

### dv/tb.sv
// tb: stimulus and verdict for timer_table_engine_top
// depends on tte_pkg, tte_checker and the engine rtl
module tb;
  import tte_pkg::*;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  start = 0;
  logic                  busy;
  logic [2:0]            in_opcode = 0;
  logic [5:0]            in_slot_id = 0;
  logic                  in_one_shot = 0;
  logic [7:0]            in_owner_module = 0;
  logic [DELAY_W-1:0]    in_delay_ms = 0;
  logic                  out_strobe, out_kind, out_status, out_last;
  logic [SLOT_OUT_W-1:0] out_slot_out;
  int                    fail_count, pending;
  int                    cycles = 0;

  localparam int LIMIT = 400000;

  always #6 clk = ~clk;

  timer_table_engine_top uut (.*);
  tte_checker chk (.*);

  // watchdog on total cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[timer_table_engine_top] ERROR");
      $finish;
    end
  end

  // one request: hold start until the engine takes it
  task automatic send(logic [2:0] op, logic [5:0] sid, logic osh,
                      logic [7:0] own, logic [DELAY_W-1:0] dly);
    start <= 1; in_opcode <= op; in_slot_id <= sid; in_one_shot <= osh;
    in_owner_module <= own; in_delay_ms <= dly;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic go_quiet(int n);
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // delays kept short so timers actually fire; sometimes a huge one
  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0: return DELAY_W'($urandom);
      1: return 24'hFFFFFF;
      default: return DELAY_W'($urandom_range(0, 2000));
    endcase
  endfunction

  task automatic random_request();
    logic [2:0] op;
    logic [5:0] sid;
    int r;
    r = $urandom_range(0, 99);
    // mostly valid commands on live-ish slots, some noise
    if (r < 20) op = OP_CREATE;
    else if (r < 30) op = OP_DELETE;
    else if (r < 50) op = OP_START;
    else if (r < 58) op = OP_STOP;
    else if (r < 96) op = OP_TICK;
    else op = 3'($urandom_range(5, 7));
    sid = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
    send(op, sid, 1'($urandom),
         ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 99)),
         pick_delay());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fill the table, over-fill, bad owners
    for (int i = 0; i < 16; i++) send(OP_CREATE, 0, i[0], 8'(i), 0);
    send(OP_CREATE, 0, 0, 8'd0, 0);       // no free slot
    send(OP_DELETE, 6'd3, 0, 0, 0);
    send(OP_CREATE, 0, 1, 8'd100, 0);     // owner too large
    send(OP_CREATE, 0, 1, 8'd255, 0);
    send(OP_CREATE, 0, 0, 8'd99, 0);      // reuses freed id
    send(OP_START, 6'd63, 0, 0, 24'hFFFFFF); // slot out of range
    send(OP_STOP, 6'd40, 0, 0, 0);
    send(OP_START, 6'd0, 0, 0, 24'd0);    // zero period
    send(OP_START, 6'd1, 0, 0, 24'd400);
    send(OP_START, 6'd1, 0, 0, 24'd200);  // restart while running
    send(OP_START, 6'd2, 0, 0, 24'hFFFFFF); // long period wraps
    for (int i = 0; i < 16; i++) send(OP_START, 6'(i), 0, 0, 24'd0); // many expiries
    send(OP_TICK, 0, 0, 0, 0);
    send(OP_STOP, 6'd5, 0, 0, 0);
    send(OP_TICK, 0, 0, 0, 0);
    send(3'd5, 0, 0, 0, 0);
    send(3'd7, 6'd63, 1, 8'hFF, 24'hFFFFFF);
    // pause until everything has drained
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 16; i++) send(OP_DELETE, 6'(i), 0, 0, 0);
    send(OP_DELETE, 6'd0, 0, 0, 0);       // delete of a free slot

    // random bursts with gaps
    for (int n = 0; n < 400; ) begin
      int burst;
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        random_request();
        n++;
      end
      go_quiet($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30));
    end

    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("[timer_table_engine_top] OK");
    else $display("[timer_table_engine_top] ERROR");
    $finish;
  end

endmodule

### timer_table_engine_top.f
sv/tte_pkg.sv
sv/tte_datapath.sv
sv/tte_ctrl.sv
sv/timer_table_engine_top.sv
dv/tte_checker.sv
dv/tb.sv
